// ----- src/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

    localparam logic [7:0]  SOF_BYTE        = 8'hAA;
    localparam logic [7:0]  ESC_BYTE        = 8'h1B;
    localparam logic [7:0]  ESC_XOR         = 8'h20;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] MAX_STUFFED_LEN = 16'd512;
    localparam logic [8:0]  MAX_PAYLOAD_LEN = 9'd256;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_CRC    = 2'd2,
        ERR_FORMAT = 2'd3
    } err_t;

    typedef struct packed {
        logic [8:0] payload_count;
        err_t       error_code;
        logic [7:0] seq_num;
        logic [7:0] frame_type;
        logic [7:0] data_byte;
        kind_t      out_kind;
    } result_t;

    // crc-16-ccitt, msb first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/sfr_in_stage.sv -----
`default_nettype none

module sfr_in_stage
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // rx_byte
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_out
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_axis_tready = !valid_reg || take;
    assign byte_valid    = valid_reg;
    assign byte_out      = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_decoder.sv -----
`default_nettype none

module sfr_decoder
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic [7:0] rx_byte,
    input  wire logic       take,
    output logic            res_valid,
    output result_t         res
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } phase_t;

    phase_t      phase_reg,          phase_next;
    logic [31:0] header_store_reg,   header_store_next;
    logic [2:0]  header_fill_reg,    header_fill_next;
    logic [15:0] stuffed_left_reg,   stuffed_left_next;
    logic        escape_pending_reg, escape_pending_next;
    logic [15:0] running_crc_reg,    running_crc_next;
    logic [8:0]  decoded_count_reg,  decoded_count_next;
    logic [7:0]  crc_low_byte_reg,   crc_low_byte_next;
    logic        crc_second_reg,     crc_second_next;
    logic        format_bad_reg,     format_bad_next;

    logic [31:0] store_n;
    logic [15:0] crc_n;
    logic [15:0] left_dec;
    logic [15:0] rx_crc;
    logic [7:0]  value;
    logic        produce;
    logic [15:0] c_b1, c_b12, c_b123, c_b2, c_b23, c_b3;

    always_comb
    begin
        phase_next          = phase_reg;
        header_store_next   = header_store_reg;
        header_fill_next    = header_fill_reg;
        stuffed_left_next   = stuffed_left_reg;
        escape_pending_next = escape_pending_reg;
        running_crc_next    = running_crc_reg;
        decoded_count_next  = decoded_count_reg;
        crc_low_byte_next   = crc_low_byte_reg;
        crc_second_next     = crc_second_reg;
        format_bad_next     = format_bad_reg;

        store_n  = header_store_reg | ({24'h0, rx_byte} << {header_fill_reg[1:0], 3'b000});
        crc_n    = crc_byte(running_crc_reg, rx_byte);
        left_dec = stuffed_left_reg - 16'd1;
        rx_crc   = {rx_byte, crc_low_byte_reg};
        value    = rx_byte;
        produce  = 1'b0;

        // crc of the header bytes that follow a start byte found on rescan
        c_b1   = crc_byte(CRC_INIT, store_n[15:8]);
        c_b12  = crc_byte(c_b1, store_n[23:16]);
        c_b123 = crc_byte(c_b12, store_n[31:24]);
        c_b2   = crc_byte(CRC_INIT, store_n[23:16]);
        c_b23  = crc_byte(c_b2, store_n[31:24]);
        c_b3   = crc_byte(CRC_INIT, store_n[31:24]);

        res_valid         = 1'b0;
        res.out_kind      = KIND_DATA;
        res.data_byte     = 8'h00;
        res.frame_type    = header_store_reg[7:0];
        res.seq_num       = header_store_reg[15:8];
        res.error_code    = ERR_NONE;
        res.payload_count = decoded_count_reg;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == SOF_BYTE)
                begin
                    phase_next          = PH_HEADER;
                    header_store_next   = 32'h0;
                    header_fill_next    = 3'd0;
                    stuffed_left_next   = 16'h0;
                    escape_pending_next = 1'b0;
                    running_crc_next    = CRC_INIT;
                    decoded_count_next  = 9'd0;
                    crc_low_byte_next   = 8'h00;
                    crc_second_next     = 1'b0;
                    format_bad_next     = 1'b0;
                end
            end
            PH_HEADER:
            begin
                header_store_next = store_n;
                running_crc_next  = crc_n;
                header_fill_next  = header_fill_reg + 3'd1;
                if (header_fill_reg == 3'd3)
                begin
                    if (store_n[31:16] > MAX_STUFFED_LEN)
                    begin
                        res_valid         = 1'b1;
                        res.out_kind      = KIND_REJECT;
                        res.frame_type    = store_n[7:0];
                        res.seq_num       = store_n[15:8];
                        res.error_code    = ERR_LENGTH;
                        res.payload_count = 9'd0;

                        stuffed_left_next   = 16'h0;
                        escape_pending_next = 1'b0;
                        decoded_count_next  = 9'd0;
                        crc_low_byte_next   = 8'h00;
                        crc_second_next     = 1'b0;
                        format_bad_next     = 1'b0;
                        // rescan the stored header for a start byte
                        if (store_n[7:0] == SOF_BYTE)
                        begin
                            phase_next        = PH_HEADER;
                            header_store_next = {8'h00, store_n[31:8]};
                            header_fill_next  = 3'd3;
                            running_crc_next  = c_b123;
                        end
                        else if (store_n[15:8] == SOF_BYTE)
                        begin
                            phase_next        = PH_HEADER;
                            header_store_next = {16'h0, store_n[31:16]};
                            header_fill_next  = 3'd2;
                            running_crc_next  = c_b23;
                        end
                        else if (store_n[23:16] == SOF_BYTE)
                        begin
                            phase_next        = PH_HEADER;
                            header_store_next = {24'h0, store_n[31:24]};
                            header_fill_next  = 3'd1;
                            running_crc_next  = c_b3;
                        end
                        else if (store_n[31:24] == SOF_BYTE)
                        begin
                            phase_next        = PH_HEADER;
                            header_store_next = 32'h0;
                            header_fill_next  = 3'd0;
                            running_crc_next  = CRC_INIT;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    else
                    begin
                        stuffed_left_next = store_n[31:16];
                        phase_next = (store_n[31:16] != 16'h0) ? PH_PAYLOAD : PH_CRC;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                running_crc_next  = crc_n;
                stuffed_left_next = left_dec;
                if (left_dec == 16'h0)
                begin
                    phase_next = PH_CRC;
                end
                if (escape_pending_reg)
                begin
                    value               = rx_byte ^ ESC_XOR;
                    escape_pending_next = 1'b0;
                    produce             = 1'b1;
                end
                else if (rx_byte == ESC_BYTE)
                begin
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    produce = 1'b1;
                end
                if (produce && !format_bad_reg)
                begin
                    if (decoded_count_reg >= MAX_PAYLOAD_LEN)
                    begin
                        format_bad_next = 1'b1;
                    end
                    else
                    begin
                        decoded_count_next = decoded_count_reg + 9'd1;
                        res_valid          = 1'b1;
                        res.out_kind       = KIND_DATA;
                        res.data_byte      = value;
                        res.payload_count  = decoded_count_reg + 9'd1;
                    end
                end
            end
            PH_CRC:
            begin
                if (!crc_second_reg)
                begin
                    crc_low_byte_next = rx_byte;
                    crc_second_next   = 1'b1;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    if (rx_crc != running_crc_reg)
                    begin
                        res.out_kind   = KIND_REJECT;
                        res.error_code = ERR_CRC;
                    end
                    else if (format_bad_reg || escape_pending_reg)
                    begin
                        res.out_kind   = KIND_REJECT;
                        res.error_code = ERR_FORMAT;
                    end
                    else
                    begin
                        res.out_kind = KIND_ACCEPT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        res_valid = res_valid && byte_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            header_store_reg   <= 32'h0;
            header_fill_reg    <= 3'd0;
            stuffed_left_reg   <= 16'h0;
            escape_pending_reg <= 1'b0;
            running_crc_reg    <= CRC_INIT;
            decoded_count_reg  <= 9'd0;
            crc_low_byte_reg   <= 8'h00;
            crc_second_reg     <= 1'b0;
            format_bad_reg     <= 1'b0;
        end
        else if (byte_valid && take)
        begin
            phase_reg          <= phase_next;
            header_store_reg   <= header_store_next;
            header_fill_reg    <= header_fill_next;
            stuffed_left_reg   <= stuffed_left_next;
            escape_pending_reg <= escape_pending_next;
            running_crc_reg    <= running_crc_next;
            decoded_count_reg  <= decoded_count_next;
            crc_low_byte_reg   <= crc_low_byte_next;
            crc_second_reg     <= crc_second_next;
            format_bad_reg     <= format_bad_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_out_stage.sv -----
`default_nettype none

module sfr_out_stage
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire result_t     res,
    output logic             take,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // data_byte, frame_type, seq_num, error_code, payload_count
    output logic [1:0]       m_axis_tuser   // out_kind
);

    logic    valid_reg;
    result_t res_reg;

    // the result register is free when empty or its request is taken now
    assign take          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.out_kind;
    assign m_axis_tdata  = {5'b00000, res_reg.payload_count, res_reg.error_code,
                            res_reg.seq_num, res_reg.frame_type, res_reg.data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- src/stuffed_frame_receiver_top.sv -----
`default_nettype none

// Receiver for byte-stuffed frames: start byte 0xAA, type, sequence number,
// 16-bit stuffed length (low byte first), stuffed payload (0x1B escapes the next
// byte, xored with 0x20) and a crc-16-ccitt (init 0xFFFF) over header and stuffed
// bytes. Each decoded payload byte is delivered at once as a tentative result,
// and the frame closes with one accept or reject request (length, crc or format
// error, crc first). One byte is taken per clock cycle unless stalled: the input register, the
// decode and crc logic and the result register form a two-stage pipeline, so a result is
// registered in the result register from the byte held in the input register, and the
// input stalls only when a byte waits in the input register while the result
// register is full and not taken.
module stuffed_frame_receiver_top
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // data_byte, frame_type, seq_num, error_code, payload_count
    output logic [1:0]       m_axis_tuser   // out_kind
);

    logic       take;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       res_valid;
    result_t    res;

    sfr_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .byte_valid    (byte_valid),
        .byte_out      (byte_data)
    );

    sfr_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (byte_data),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfr_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- dv/stuffed_frame_receiver_top_tb.sv -----
`timescale 1ns / 100ps

module stuffed_frame_receiver_top_tb;
    import sfr_pkg::*;

    localparam int ITEM_TARGET  = 1950;
    localparam int CALM_ITEMS   = 250;
    localparam int PRESSURE_AT  = 600;
    localparam int SINK_HOLD    = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {ST_HUNT, ST_HEADER, ST_PAYLOAD, ST_CRC} rx_state_t;
    typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_BAD} row_op_t;

    typedef struct {
        row_op_t    op;
        logic [7:0] val;
        bit         typed;
        result_t    want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // receiver model state
    rx_state_t   rx_state;
    logic [31:0] hdr_bytes;
    logic [2:0]  hdr_cnt;
    logic [15:0] stuffed_rem;
    bit          esc_seen;
    logic [15:0] crc_acc;
    logic [8:0]  out_cnt;
    logic [7:0]  crc_lo;
    bit          crc_hi_due;
    bit          fmt_err;

    result_t     expected_results[$];
    int          fail_count = 0;
    int          items_counted = 0;
    int          quiet_cycles = 0;
    bit          idle_on;
    bit          calm;
    bit          sink_hold_req;

    stuffed_frame_receiver_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bitwise form of the ccitt update, one input bit per step
    function automatic logic [15:0] ccitt_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        bit          fb;
        c = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] d,
                                            input logic [7:0] mt, input logic [7:0] sq,
                                            input err_t e, input logic [8:0] n);
        result_t r;
        r.out_kind      = k;
        r.data_byte     = d;
        r.frame_type    = mt;
        r.seq_num       = sq;
        r.error_code    = e;
        r.payload_count = n;
        return r;
    endfunction

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(0, 9))
            0: return SOF_BYTE;
            1: return ESC_BYTE;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic frame_begin();
        rx_state    = ST_HEADER;
        hdr_bytes   = '0;
        hdr_cnt     = '0;
        stuffed_rem = '0;
        esc_seen    = 1'b0;
        crc_acc     = CRC_INIT;
        out_cnt     = '0;
        crc_lo      = '0;
        crc_hi_due  = 1'b0;
        fmt_err     = 1'b0;
    endtask

    task automatic hdr_push(input logic [7:0] b);
        hdr_bytes = hdr_bytes | (32'(b) << (8 * hdr_cnt[1:0]));
        crc_acc   = ccitt_next(crc_acc, b);
        hdr_cnt   = hdr_cnt + 3'd1;
    endtask

    task automatic frame_model(input logic [7:0] b, output bit hit, output result_t res,
                               output bit ignored);
        logic [31:0] saved;
        logic [15:0] len;
        logic [7:0]  val;
        bit          found;
        bit          produce;
        hit     = 1'b0;
        ignored = 1'b0;
        res     = '0;
        case (rx_state)
            ST_HUNT:
            begin
                ignored = (b != SOF_BYTE);
                if (!ignored)
                    frame_begin();
            end
            ST_HEADER:
            begin
                hdr_push(b);
                if (hdr_cnt == 3'd4)
                begin
                    len = hdr_bytes[31:16];
                    if (len > MAX_STUFFED_LEN)
                    begin
                        hit = 1'b1;
                        res = make_result(KIND_REJECT, 8'h00, hdr_bytes[7:0], hdr_bytes[15:8],
                                          ERR_LENGTH, 9'd0);
                        // look for a start byte among the four header bytes
                        saved    = hdr_bytes;
                        rx_state = ST_HUNT;
                        found    = 1'b0;
                        for (int p = 0; p < 4; p++)
                        begin
                            if (!found && saved[8*p +: 8] == SOF_BYTE)
                            begin
                                found = 1'b1;
                                frame_begin();
                                for (int q = p + 1; q < 4; q++)
                                    hdr_push(saved[8*q +: 8]);
                            end
                        end
                    end
                    else
                    begin
                        stuffed_rem = len;
                        rx_state    = (len == 16'd0) ? ST_CRC : ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                val         = b;
                produce     = 1'b0;
                crc_acc     = ccitt_next(crc_acc, b);
                stuffed_rem = stuffed_rem - 16'd1;
                if (stuffed_rem == 16'd0)
                    rx_state = ST_CRC;
                if (esc_seen)
                begin
                    val      = b ^ ESC_XOR;
                    esc_seen = 1'b0;
                    produce  = 1'b1;
                end
                else if (b == ESC_BYTE)
                    esc_seen = 1'b1;
                else
                    produce = 1'b1;
                if (produce && !fmt_err)
                begin
                    if (out_cnt >= MAX_PAYLOAD_LEN)
                        fmt_err = 1'b1;
                    else
                    begin
                        out_cnt = out_cnt + 9'd1;
                        hit     = 1'b1;
                        res     = make_result(KIND_DATA, val, hdr_bytes[7:0], hdr_bytes[15:8],
                                              ERR_NONE, out_cnt);
                    end
                end
            end
            default:
            begin
                if (!crc_hi_due)
                begin
                    crc_lo     = b;
                    crc_hi_due = 1'b1;
                end
                else
                begin
                    rx_state = ST_HUNT;
                    hit      = 1'b1;
                    if ({b, crc_lo} != crc_acc)
                        res = make_result(KIND_REJECT, 8'h00, hdr_bytes[7:0], hdr_bytes[15:8],
                                          ERR_CRC, out_cnt);
                    else if (fmt_err || esc_seen)
                        res = make_result(KIND_REJECT, 8'h00, hdr_bytes[7:0], hdr_bytes[15:8],
                                          ERR_FORMAT, out_cnt);
                    else
                        res = make_result(KIND_ACCEPT, 8'h00, hdr_bytes[7:0], hdr_bytes[15:8],
                                          ERR_NONE, out_cnt);
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        bit      hit;
        bit      ignored;
        result_t res;
        if (idle_on && !calm && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        frame_model(b, hit, res, ignored);
        if (typed)
            expected_results.push_back(want);
        else if (hit)
            expected_results.push_back(res);
        if (!ignored)
            items_counted++;
        calm = (items_counted >= ITEM_TARGET - CALM_ITEMS);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin : stimulus
        row_t        dir_tab [24];
        result_t     none;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [7:0]  frm[$];
        logic [7:0]  stf[$];
        logic [15:0] len;
        logic [15:0] crc;
        int          sel;
        int          dlen;
        bit          pressure_done;
        bit          pressure_now;
        none          = '0;
        pressure_done = 1'b0;
        idle_on       = 1'b1;
        calm          = 1'b0;
        sink_hold_req = 1'b0;
        frame_begin();
        rx_state = ST_HUNT;
        dir_tab = '{
            '{ROW_BYTE,    8'h55, 1'b0, none},  // dropped while hunting
            '{ROW_BYTE,    8'hAA, 1'b0, none},
            '{ROW_BYTE,    8'hFF, 1'b0, none},
            '{ROW_BYTE,    8'h00, 1'b0, none},
            '{ROW_BYTE,    8'h00, 1'b0, none},
            '{ROW_BYTE,    8'h00, 1'b0, none},  // zero length, crc follows
            '{ROW_CRC_LO,  8'h00, 1'b0, none},
            '{ROW_CRC_HI,  8'h00, 1'b1,
              make_result(KIND_ACCEPT, 8'h00, 8'hFF, 8'h00, ERR_NONE, 9'd0)},
            '{ROW_BYTE,    8'hAA, 1'b0, none},
            '{ROW_BYTE,    8'hAA, 1'b0, none},  // start byte as type, found on rescan
            '{ROW_BYTE,    8'h34, 1'b0, none},
            '{ROW_BYTE,    8'h00, 1'b0, none},
            '{ROW_BYTE,    8'hFF, 1'b1,
              make_result(KIND_REJECT, 8'h00, 8'hAA, 8'h34, ERR_LENGTH, 9'd0)},
            '{ROW_BYTE,    8'h02, 1'b1,
              make_result(KIND_REJECT, 8'h00, 8'h34, 8'h00, ERR_LENGTH, 9'd0)},
            '{ROW_BYTE,    8'hAA, 1'b0, none},
            '{ROW_BYTE,    8'h00, 1'b0, none},
            '{ROW_BYTE,    8'hFF, 1'b0, none},
            '{ROW_BYTE,    8'h03, 1'b0, none},
            '{ROW_BYTE,    8'h00, 1'b0, none},
            '{ROW_BYTE,    8'h1B, 1'b0, none},
            '{ROW_BYTE,    8'h3B, 1'b0, none},
            '{ROW_BYTE,    8'h1B, 1'b0, none},  // dangling escape
            '{ROW_CRC_LO,  8'h00, 1'b0, none},
            '{ROW_CRC_BAD, 8'h00, 1'b1,
              make_result(KIND_REJECT, 8'h00, 8'h00, 8'hFF, ERR_CRC, 9'd1)}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            case (dir_tab[i].op)
                ROW_CRC_LO:  b = crc_acc[7:0];
                ROW_CRC_HI:  b = crc_acc[15:8];
                ROW_CRC_BAD: b = ~crc_acc[15:8];
                default:     b = dir_tab[i].val;
            endcase
            send_byte(b, dir_tab[i].typed, dir_tab[i].want);
        end

        while (items_counted < ITEM_TARGET)
        begin
            idle_on      = ($urandom_range(0, 3) != 0);
            sel          = $urandom_range(0, 99);
            pressure_now = 1'b0;
            frm.delete();
            stf.delete();
            if (!pressure_done && items_counted >= PRESSURE_AT)
            begin
                // drain everything, then stall the sink while a long frame is offered
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
                sink_hold_req = 1'b1;
                idle_on       = 1'b0;
                pressure_done = 1'b1;
                pressure_now  = 1'b1;
                sel           = 99;
            end
            if (sel < 8)
            begin
                repeat ($urandom_range(1, 6))
                    frm.push_back(rnd_byte());
            end
            else if (sel < 14)
            begin
                case ($urandom_range(0, 2))
                    0:       len = MAX_STUFFED_LEN + 16'd1;
                    1:       len = 16'hFFFF;
                    default: len = 16'($urandom_range(513, 65535));
                endcase
                frm.push_back(SOF_BYTE);
                frm.push_back(rnd_byte());
                frm.push_back(rnd_byte());
                frm.push_back(len[7:0]);
                frm.push_back(len[15:8]);
            end
            else
            begin
                if (pressure_now)
                    dlen = 24;
                else if (sel == 14)
                    dlen = 256;
                else if (sel < 18)
                    dlen = $urandom_range(250, 270);
                else
                    dlen = $urandom_range(0, 10);
                for (int k = 0; k < dlen; k++)
                begin
                    v = rnd_byte();
                    // sel 14 escapes every byte to hit the stuffed length limit exactly
                    if (sel == 14 || v == ESC_BYTE || $urandom_range(0, 7) == 0)
                    begin
                        stf.push_back(ESC_BYTE);
                        stf.push_back(v ^ ESC_XOR);
                    end
                    else
                        stf.push_back(v);
                end
                if (sel >= 18 && sel < 23)
                    stf.push_back(ESC_BYTE);
                len = 16'(stf.size());
                frm.push_back(SOF_BYTE);
                frm.push_back(rnd_byte());
                frm.push_back(rnd_byte());
                frm.push_back(len[7:0]);
                frm.push_back(len[15:8]);
                foreach (stf[k])
                    frm.push_back(stf[k]);
                crc = CRC_INIT;
                for (int k = 1; k < frm.size(); k++)
                    crc = ccitt_next(crc, frm[k]);
                if (sel >= 23 && sel < 31)
                    crc = crc ^ (16'h0001 << $urandom_range(0, 15));
                frm.push_back(crc[7:0]);
                frm.push_back(crc[15:8]);
            end
            foreach (frm[k])
                send_byte(frm[k], 1'b0, none);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : sink_ctrl
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
            end
            else if (idle_on && !calm && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind 0x%0h, data 0x%0h", m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_kind", 16'(want.out_kind), 16'(m_axis_tuser));
                check_field("data_byte", 16'(want.data_byte), 16'(m_axis_tdata[7:0]));
                check_field("frame_type", 16'(want.frame_type), 16'(m_axis_tdata[15:8]));
                check_field("seq_num", 16'(want.seq_num), 16'(m_axis_tdata[23:16]));
                check_field("error_code", 16'(want.error_code), 16'(m_axis_tdata[25:24]));
                check_field("payload_count", 16'(want.payload_count),
                            16'(m_axis_tdata[34:26]));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// ----- files.f -----
src/sfr_pkg.sv
src/sfr_in_stage.sv
src/sfr_decoder.sv
src/sfr_out_stage.sv
src/stuffed_frame_receiver_top.sv
dv/stuffed_frame_receiver_top_tb.sv
